>>> hw/rtl/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types and constants of the 3x3 convolution image filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

   localparam int PIX_W   = 16;
   localparam int COEF_W  = 48;
   localparam int SCALE_W = 24;
   localparam int BIAS_W  = 17;
   localparam int LW_W    = 13;
   localparam int CSR_IDX_W = 3;

   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [COEF_W-1:0]     coef_row_type;
   typedef logic [SCALE_W-1:0]    scale_type;
   typedef logic signed [BIAS_W-1:0] bias_type;
   typedef logic [LW_W-1:0]       lw_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // Register indexes of the configuration port
   localparam csr_idx_type CSR_COEF_TOP    = 3'd0;
   localparam csr_idx_type CSR_COEF_MID    = 3'd1;
   localparam csr_idx_type CSR_COEF_BOTTOM = 3'd2;
   localparam csr_idx_type CSR_SCALE       = 3'd3;
   localparam csr_idx_type CSR_BIAS        = 3'd4;
   localparam csr_idx_type CSR_DEEP        = 3'd5;
   localparam csr_idx_type CSR_LINE_WIDTH  = 3'd6;

   // Values for the action field
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

endpackage

>>> hw/rtl/c3f_filter.sv
// ----------------------------------------------------------------------------
// c3f_filter
// Multi-cycle filter unit: nine-tap MAC, split scale multiply, bias,
// truncation toward zero and clamp. Window must hold while busy.
// ----------------------------------------------------------------------------
module c3f_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  c3f_pkg::pix_type      win [9],
   input  c3f_pkg::coef_row_type coef_top,
   input  c3f_pkg::coef_row_type coef_mid,
   input  c3f_pkg::coef_row_type coef_bottom,
   input  c3f_pkg::scale_type    scale,
   input  c3f_pkg::bias_type     bias,
   input  logic                  deep,
   output logic                  done,
   output c3f_pkg::pix_type      result
);
   import c3f_pkg::*;

   localparam int ACC_W = 37;
   localparam int T_W   = 64;

   typedef enum logic [2:0] {F_IDLE, F_MAC, F_MUL, F_ADD, F_CLAMP} fstate_type;

   fstate_type              state_ff;
   logic [3:0]              cnt_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [41:0]             p0_ff;
   logic signed [43:0]      p1_ff;
   logic signed [T_W-1:0]   t_ff;
   logic                    done_ff;
   pix_type                 res_ff;

   logic signed [15:0]      taps [9];
   logic signed [32:0]      prod;
   logic signed [T_W-1:0]   q;
   pix_type                 clamp_in;

   // Unpack the nine signed weights
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         taps[i]     = coef_top[16*i +: 16];
         taps[3 + i] = coef_mid[16*i +: 16];
         taps[6 + i] = coef_bottom[16*i +: 16];
      end
   end

   assign prod = taps[cnt_ff] * $signed({1'b0, win[cnt_ff]});

   // Truncate toward zero, then clamp to the pixel range
   always_comb begin
      q = t_ff[T_W-1] ? ((t_ff + T_W'(65535)) >>> 16) : (t_ff >>> 16);
      if (q < 0) begin
         clamp_in = '0;
      end else if (deep && q > T_W'(65535)) begin
         clamp_in = 16'hFFFF;
      end else if (!deep && q > T_W'(255)) begin
         clamp_in = 16'h00FF;
      end else begin
         clamp_in = q[15:0];
      end
   end

   // Sequence MAC, multiply, add and clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  state_ff <= F_MAC;
                  cnt_ff   <= '0;
                  acc_ff   <= '0;
               end
            end
            F_MAC: begin
               acc_ff <= acc_ff + ACC_W'(prod);
               if (cnt_ff == 4'd8) begin
                  state_ff <= F_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            F_MUL: begin
               p0_ff    <= acc_ff[17:0] * scale;
               p1_ff    <= $signed(acc_ff[ACC_W-1:18]) * $signed({1'b0, scale});
               state_ff <= F_ADD;
            end
            F_ADD: begin
               t_ff <= (T_W'(p1_ff) <<< 18) + $signed(T_W'(p0_ff))
                       + (T_W'(bias) <<< 16);
               state_ff <= F_CLAMP;
            end
            F_CLAMP: begin
               res_ff   <= clamp_in;
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> hw/rtl/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster stream with two line stores in memory.
// ----------------------------------------------------------------------------
// Past the first row, each pixel beat after the first column and each flush beat
//   start the filter once no result waits; a line end yields a second result.
// The input stalls until an item is through, pacing items by the one-tap-per-cycle
//   MAC of the shared filter unit and the single read port of each line store.
// Reset clears control and position state; line stores are not cleared.
module conv3x3_image_filter #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  c3f_pkg::pix_type      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output c3f_pkg::pix_type      rsp_pixel_out,
   output logic                  rsp_end_of_line,
   output logic                  rsp_end_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  c3f_pkg::csr_idx_type  csr_index,
   input  logic [47:0]           csr_data
);
   import c3f_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PIX, S_FL1, S_FL2, S_FL3, S_EDGE, S_LAUNCH, S_BUSY
   } state_type;

   // configuration
   coef_row_type coef_top_ff, coef_mid_ff, coef_bottom_ff;
   scale_type    scale_ff;
   bias_type     bias_ff;
   logic         deep_ff;
   lw_type       lw_ff;

   // line stores
   pix_type      store_a [MAX_WIDTH];
   pix_type      store_b [MAX_WIDTH];
   pix_type      rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_addr;
   logic         wr_en;
   pix_type      wr_a, wr_b;

   // control
   state_type    state_ff;
   logic [AW-1:0] col_ff, flush_ff, cur_ff, xs1_ff, xs2_ff;
   logic [1:0]   row_ff;
   pix_type      px_ff;
   pix_type      win_ff [9];
   logic         second_ff, eol_ff, eof_ff, fl_last_ff;

   logic         rsp_valid_ff, rsp_eol_ff, rsp_eof_ff;
   pix_type      rsp_pix_ff;

   logic [WW-1:0] eff_w;
   logic [AW-1:0] wm1, c_now, f_now, xs0, xs2;
   logic         req_acc;
   pix_type      col [3];
   logic         pix_last;
   logic         f_start, f_done;
   pix_type      f_result;

   // Effective width, clipped to 1..MAX_WIDTH
   always_comb begin
      if (lw_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(lw_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(lw_ff);
      end
   end
   assign wm1 = AW'(eff_w - WW'(1));

   assign c_now = (col_ff > wm1) ? wm1 : col_ff;
   assign f_now = (flush_ff > wm1) ? wm1 : flush_ff;
   assign xs0   = (f_now != '0) ? f_now - AW'(1) : '0;
   assign xs2   = (f_now == wm1) ? f_now : f_now + AW'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff    <= '0;
         coef_mid_ff    <= COEF_W'(65536);
         coef_bottom_ff <= '0;
         scale_ff       <= SCALE_W'(65536);
         bias_ff        <= '0;
         deep_ff        <= 1'b0;
         lw_ff          <= LW_W'(4096);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_TOP:    coef_top_ff    <= csr_data;
            CSR_COEF_MID:    coef_mid_ff    <= csr_data;
            CSR_COEF_BOTTOM: coef_bottom_ff <= csr_data;
            CSR_SCALE:       scale_ff       <= csr_data[SCALE_W-1:0];
            CSR_BIAS:        bias_ff        <= csr_data[BIAS_W-1:0];
            CSR_DEEP:        deep_ff        <= csr_data[0];
            CSR_LINE_WIDTH:  lw_ff          <= csr_data[LW_W-1:0];
            default: ;
         endcase
      end
   end

   // Select the store read address per state
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = (req_action == ACT_FLUSH) ? xs0 : c_now;
         S_FL1:   rd_addr = xs1_ff;
         S_FL2:   rd_addr = xs2_ff;
         default: rd_addr = cur_ff;
      endcase
   end

   // Build the new window column from the previous rows
   always_comb begin
      if (row_ff == 2'd0) begin
         col[0] = px_ff;
         col[1] = px_ff;
         col[2] = px_ff;
         wr_b   = px_ff;
      end else begin
         col[0] = (row_ff == 2'd1) ? rd_a_ff : rd_b_ff;
         col[1] = rd_a_ff;
         col[2] = px_ff;
         wr_b   = rd_a_ff;
      end
      wr_a  = px_ff;
      wr_en = (state_ff == S_PIX);
   end
   assign pix_last = (cur_ff == wm1);

   // Line store memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a[cur_ff] <= wr_a;
         store_b[cur_ff] <= wr_b;
      end
      rd_a_ff <= store_a[rd_addr];
      rd_b_ff <= store_b[rd_addr];
   end

   // Sequence one item at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         flush_ff  <= '0;
         second_ff <= 1'b0;
         eol_ff    <= 1'b0;
         eof_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (req_action == ACT_PIXEL) begin
                     if (flush_ff == '0) begin
                        cur_ff   <= c_now;
                        px_ff    <= deep_ff ? req_pixel_in : {8'h00, req_pixel_in[7:0]};
                        state_ff <= S_PIX;
                     end
                  end else if (row_ff != 2'd0 && col_ff == '0) begin
                     xs1_ff     <= f_now;
                     xs2_ff     <= xs2;
                     fl_last_ff <= (f_now == wm1);
                     state_ff   <= S_FL1;
                  end
               end
            end
            S_PIX: begin
               for (int r = 0; r < 3; r++) begin
                  if (cur_ff == '0) begin
                     win_ff[r*3]     <= col[r];
                     win_ff[r*3 + 1] <= col[r];
                  end else begin
                     win_ff[r*3]     <= win_ff[r*3 + 1];
                     win_ff[r*3 + 1] <= win_ff[r*3 + 2];
                  end
                  win_ff[r*3 + 2] <= col[r];
               end
               col_ff <= pix_last ? '0 : cur_ff + AW'(1);
               if (pix_last && row_ff != 2'd2) begin
                  row_ff <= row_ff + 2'd1;
               end
               eol_ff    <= 1'b0;
               eof_ff    <= 1'b0;
               second_ff <= (row_ff != 2'd0) && pix_last;
               if (row_ff != 2'd0 && cur_ff != '0) begin
                  state_ff <= S_LAUNCH;
               end else if (row_ff != 2'd0 && pix_last) begin
                  state_ff <= S_EDGE;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FL1, S_FL2, S_FL3: begin
               // place the column read for the previous address
               for (int k = 0; k < 3; k++) begin
                  if ((state_ff == S_FL1 && k == 0) || (state_ff == S_FL2 && k == 1)
                      || (state_ff == S_FL3 && k == 2)) begin
                     win_ff[k]     <= (row_ff == 2'd1) ? rd_a_ff : rd_b_ff;
                     win_ff[3 + k] <= rd_a_ff;
                     win_ff[6 + k] <= rd_a_ff;
                  end
               end
               if (state_ff == S_FL1) begin
                  state_ff <= S_FL2;
               end else if (state_ff == S_FL2) begin
                  state_ff <= S_FL3;
               end else begin
                  eol_ff    <= fl_last_ff;
                  eof_ff    <= fl_last_ff;
                  second_ff <= 1'b0;
                  if (fl_last_ff) begin
                     flush_ff <= '0;
                     row_ff   <= '0;
                     col_ff   <= '0;
                  end else begin
                     flush_ff <= xs1_ff + AW'(1);
                  end
                  state_ff <= S_LAUNCH;
               end
            end
            S_EDGE: begin
               // replicate the right edge column
               for (int r = 0; r < 3; r++) begin
                  win_ff[r*3]     <= win_ff[r*3 + 1];
                  win_ff[r*3 + 1] <= win_ff[r*3 + 2];
               end
               second_ff <= 1'b0;
               eol_ff    <= 1'b1;
               state_ff  <= S_LAUNCH;
            end
            S_LAUNCH: begin
               if (!rsp_valid_ff) begin
                  state_ff <= S_BUSY;
               end
            end
            S_BUSY: begin
               if (f_done) begin
                  state_ff <= second_ff ? S_EDGE : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign f_start = (state_ff == S_LAUNCH) && !rsp_valid_ff;

   c3f_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .start       (f_start),
      .win         (win_ff),
      .coef_top    (coef_top_ff),
      .coef_mid    (coef_mid_ff),
      .coef_bottom (coef_bottom_ff),
      .scale       (scale_ff),
      .bias        (bias_ff),
      .deep        (deep_ff),
      .done        (f_done),
      .result      (f_result)
   );

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (f_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (f_done) begin
         rsp_pix_ff <= f_result;
         rsp_eol_ff <= eol_ff;
         rsp_eof_ff <= eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pix_ff;
   assign rsp_end_of_line  = rsp_eol_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

>>> hw/rtl/c3f_checker.sv
// ----------------------------------------------------------------------------
// c3f_checker
// Port-level checks of the 3x3 convolution image filter.
// ----------------------------------------------------------------------------
module c3f_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input c3f_pkg::pix_type rsp_pixel_out,
   input logic             rsp_end_of_line,
   input logic             rsp_end_of_frame
);
   import c3f_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result beat changed");

   // Frame end only on a line end
   a_eof_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end_of_frame without end_of_line");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Input stall is driven out of reset whenever a request is valid
   a_stall_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_stall))
      else $error("input stall unknown");

endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_out    (rsp_pixel_out),
   .rsp_end_of_line  (rsp_end_of_line),
   .rsp_end_of_frame (rsp_end_of_frame)
);
